// ===== rtl/bchc_pkg.sv =====
// Shared types, constants and register codes for the button click/hold classifier.
package bchc_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int MAX_CLICKS_DEF = 3;

    localparam int CFG_BITS  = 16;
    localparam int APB_DBITS = 32;
    localparam int APB_ABITS = 4;
    localparam int OUT_TBITS = 32;
    localparam int CODE_BITS = 3;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_CLICK_GAP  = 2'd1;
    localparam logic [1:0] REG_HOLD       = 2'd2;
    localparam logic [1:0] REG_HOLD_MIN   = 2'd3;

    localparam logic [CFG_BITS-1:0] DEBOUNCE_RST  = 16'd50;
    localparam logic [CFG_BITS-1:0] CLICK_GAP_RST = 16'd200;
    localparam logic [CFG_BITS-1:0] HOLD_RST      = 16'd1000;
    localparam logic [CFG_BITS-1:0] HOLD_MIN_RST  = 16'd500;

    // Event codes
    localparam logic [CODE_BITS-1:0] EV_NONE   = 3'd0;
    localparam logic [CODE_BITS-1:0] EV_HOLD   = 3'd4;

    typedef struct packed {
        logic [CFG_BITS-1:0] debounce_ms;
        logic [CFG_BITS-1:0] click_gap_ms;
        logic [CFG_BITS-1:0] hold_ms;
        logic [CFG_BITS-1:0] hold_report_min_ms;
    } t_cfg;

    typedef struct packed {
        logic [CODE_BITS-1:0] event_code;
        logic [OUT_TBITS-1:0] hold_duration_ms;
        logic                 hold_duration_updated;
    } t_result;

endpackage

// ===== rtl/button_click_hold_classifier.sv =====
// Top level of the debounced button single/double/triple click and hold classifier.
// A poll beat accepted at a clock edge shows its result beat right after that edge.
// Throughput: one poll per cycle while the sink keeps up; the result register frees as the sink
// takes its beat, so input and output beats can move on every cycle.
// Reset (i_rst_n low, synchronous): clears button state, output valid, and reloads
// the configuration registers with 50, 200, 1000 and 500 ms.
module button_click_hold_classifier
    import bchc_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int MAX_CLICKS = MAX_CLICKS_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // APB configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_ABITS-1:0] paddr,
    input  logic [APB_DBITS-1:0] pwdata,
    output logic [APB_DBITS-1:0] prdata,
    output logic                 pready,
    // poll input channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_pin_level,
    input  logic [31:0]          i_now_ms,
    // result channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_event_code,
    output logic [31:0]          o_hold_duration_ms,
    output logic                 o_hold_duration_updated
);

    t_cfg    w_cfg;
    t_result w_core_result;
    t_result w_out_result;
    logic    w_can_load;
    logic    w_accept;

    // Take a poll beat whenever the result register is free or draining this cycle.
    assign o_ready  = w_can_load;
    assign w_accept = i_valid && w_can_load;

    bchc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // All time differences wrap at TIME_BITS; drop the upper timestamp bits here.
    bchc_core #(
        .TIME_BITS  (TIME_BITS),
        .MAX_CLICKS (MAX_CLICKS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_pin_level (i_pin_level),
        .i_now       (i_now_ms[TIME_BITS-1:0]),
        .i_cfg       (w_cfg),
        .o_result    (w_core_result)
    );

    // Hold the finished result beat until the sink takes it.
    bchc_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_valid),
        .i_result   (w_core_result),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_can_load (w_can_load),
        .o_result   (w_out_result)
    );

    assign o_event_code            = w_out_result.event_code;
    assign o_hold_duration_ms      = w_out_result.hold_duration_ms;
    assign o_hold_duration_updated = w_out_result.hold_duration_updated;

endmodule

// ===== rtl/bchc_cfg.sv =====
// APB configuration register bank for the button click/hold classifier.
module bchc_cfg
    import bchc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_ABITS-1:0] paddr,
    input  logic [APB_DBITS-1:0] pwdata,
    output logic [APB_DBITS-1:0] prdata,
    output logic                 pready,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    logic w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms        <= DEBOUNCE_RST;
            r_cfg.click_gap_ms       <= CLICK_GAP_RST;
            r_cfg.hold_ms            <= HOLD_RST;
            r_cfg.hold_report_min_ms <= HOLD_MIN_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_DEBOUNCE:  r_cfg.debounce_ms        <= pwdata[CFG_BITS-1:0];
                REG_CLICK_GAP: r_cfg.click_gap_ms       <= pwdata[CFG_BITS-1:0];
                REG_HOLD:      r_cfg.hold_ms            <= pwdata[CFG_BITS-1:0];
                REG_HOLD_MIN:  r_cfg.hold_report_min_ms <= pwdata[CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DEBOUNCE:  prdata = APB_DBITS'(r_cfg.debounce_ms);
            REG_CLICK_GAP: prdata = APB_DBITS'(r_cfg.click_gap_ms);
            REG_HOLD:      prdata = APB_DBITS'(r_cfg.hold_ms);
            REG_HOLD_MIN:  prdata = APB_DBITS'(r_cfg.hold_report_min_ms);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/bchc_core.sv =====
// Button state registers and the per-poll debounce, click and hold update.
module bchc_core
    import bchc_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int MAX_CLICKS = MAX_CLICKS_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_pin_level,
    input  logic [TIME_BITS-1:0] i_now,
    input  t_cfg                 i_cfg,
    output t_result              o_result
);

    localparam logic [1:0] MAX_TALLY = 2'(MAX_CLICKS);

    logic [TIME_BITS-1:0] r_last_change, n_last_change;
    logic [TIME_BITS-1:0] r_hold_start,  n_hold_start;
    logic [TIME_BITS-1:0] r_rec_len,     n_rec_len;
    logic                 r_press_pending, n_press_pending;
    logic                 r_button_down,   n_button_down;
    logic                 r_arm_hold,      n_arm_hold;
    logic [1:0]           r_tally,         n_tally;

    logic [TIME_BITS-1:0] w_el_first, w_el_second, w_len;
    logic [TIME_BITS-1:0] w_lc_mid;
    logic                 w_bd_mid;
    logic [CODE_BITS-1:0] w_code;
    logic                 w_upd;

    always_comb begin
        n_last_change   = r_last_change;
        n_hold_start    = r_hold_start;
        n_rec_len       = r_rec_len;
        n_press_pending = r_press_pending;
        n_button_down   = r_button_down;
        n_arm_hold      = r_arm_hold;
        n_tally         = r_tally;
        w_code          = EV_NONE;
        w_upd           = 1'b0;
        w_el_first      = i_now - r_last_change;
        w_len           = i_now - r_hold_start;
        w_lc_mid        = r_last_change;
        w_bd_mid        = r_button_down;
        w_el_second     = '0;

        if (!i_pin_level) begin
            if (!r_press_pending && r_button_down &&
                w_el_first > TIME_BITS'(i_cfg.debounce_ms)) begin
                // end of a press: record hold length if long enough
                n_last_change = i_now;
                if (w_len > TIME_BITS'(i_cfg.hold_report_min_ms)) begin
                    n_rec_len = w_len;
                    w_upd     = 1'b1;
                end
                n_button_down = 1'b0;
                n_arm_hold    = 1'b1;
            end else begin
                if (r_press_pending && r_button_down) begin
                    w_lc_mid        = i_now;
                    n_press_pending = 1'b0;
                    if (r_tally < MAX_TALLY) begin
                        n_tally = r_tally + 2'd1;
                    end
                end
                n_last_change = w_lc_mid;
                w_el_second   = i_now - w_lc_mid;
                if (w_el_second > TIME_BITS'(i_cfg.click_gap_ms)) begin
                    w_code  = CODE_BITS'(n_tally);
                    n_tally = 2'd0;
                end
            end
        end else begin
            if (!r_button_down && w_el_first > TIME_BITS'(i_cfg.debounce_ms)) begin
                w_lc_mid        = i_now;
                w_bd_mid        = 1'b1;
                n_press_pending = 1'b1;
            end
            n_last_change = w_lc_mid;
            n_button_down = w_bd_mid;
            w_el_second   = i_now - w_lc_mid;
            if (w_bd_mid && w_el_second > TIME_BITS'(i_cfg.hold_ms)) begin
                if (r_arm_hold) begin
                    n_arm_hold   = 1'b0;
                    n_hold_start = i_now;
                end
                n_last_change   = i_now;
                n_press_pending = 1'b0;
                n_tally         = 2'd0;
                w_code          = EV_HOLD;
            end else if (r_arm_hold) begin
                n_arm_hold   = 1'b0;
                n_hold_start = i_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_change   <= '0;
            r_hold_start    <= '0;
            r_rec_len       <= '0;
            r_press_pending <= 1'b0;
            r_button_down   <= 1'b0;
            r_arm_hold      <= 1'b1;
            r_tally         <= 2'd0;
        end else if (i_accept) begin
            r_last_change   <= n_last_change;
            r_hold_start    <= n_hold_start;
            r_rec_len       <= n_rec_len;
            r_press_pending <= n_press_pending;
            r_button_down   <= n_button_down;
            r_arm_hold      <= n_arm_hold;
            r_tally         <= n_tally;
        end
    end

    assign o_result.event_code            = w_code;
    assign o_result.hold_duration_ms      = OUT_TBITS'(n_rec_len);
    assign o_result.hold_duration_updated = w_upd;

    a_pending_needs_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_press_pending |-> r_button_down)
        else $error("press pending without button down");

    a_tally_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tally <= MAX_TALLY)
        else $error("click tally above limit");

    a_update_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_upd) |-> (w_code == EV_NONE))
        else $error("hold length recorded together with an event");

    a_hold_when_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_code == EV_HOLD) |=> (r_button_down && !r_arm_hold))
        else $error("hold event without an armed hold in progress");

endmodule

// ===== rtl/bchc_out.sv =====
// Result register stage that holds one result beat until the sink takes it.
module bchc_out
    import bchc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_can_load,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== tb/sv/bchc_checker.sv =====
`timescale 1ns / 100ps
// Checker for the button click/hold classifier: mirrors its registers, predicts each poll, compares.
module bchc_checker
    import bchc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic                 i_pready,
    input  logic [APB_ABITS-1:0] i_paddr,
    input  logic [APB_DBITS-1:0] i_pwdata,
    input  logic                 i_poll_valid,
    input  logic                 i_poll_ready,
    input  logic                 i_pin_level,
    input  logic [31:0]          i_now_ms,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  logic [2:0]           i_event_code,
    input  logic [31:0]          i_hold_duration_ms,
    input  logic                 i_hold_duration_updated,
    output int                   o_mismatches,
    output int                   o_outstanding
);

    localparam int CLICK_CAP = MAX_CLICKS_DEF;

    t_cfg        cfg;
    logic [31:0] last_edge_ms;
    logic [31:0] hold_origin_ms;
    logic [31:0] held_len_ms;
    logic        click_open;
    logic        is_down;
    logic        origin_armed;
    logic [1:0]  clicks;

    t_result     expected_events[$];
    t_result     predicted;
    t_result     oldest;
    int          mismatch_cnt;
    int          in_flight;
    int          result_idx;

    assign o_mismatches  = mismatch_cnt;
    assign o_outstanding = in_flight;

    // Advance the mirrored button state by one poll and return the event it should produce.
    task automatic classify_poll(input logic level, input logic [31:0] now,
                                 output t_result res);
        logic [31:0] span;
        res.event_code            = EV_NONE;
        res.hold_duration_updated = 1'b0;
        if (!level) begin
            if (!click_open && is_down && (now - last_edge_ms) > cfg.debounce_ms) begin
                span         = now - hold_origin_ms;
                last_edge_ms = now;
                if (span > cfg.hold_report_min_ms) begin
                    held_len_ms               = span;
                    res.hold_duration_updated = 1'b1;
                end
                is_down      = 1'b0;
                origin_armed = 1'b1;
            end else begin
                // release of a fresh press counts a click at once, no debounce
                if (click_open && is_down) begin
                    last_edge_ms = now;
                    click_open   = 1'b0;
                    if (clicks < CLICK_CAP)
                        clicks = clicks + 1'b1;
                end
                if ((now - last_edge_ms) > cfg.click_gap_ms) begin
                    res.event_code = CODE_BITS'(clicks);
                    clicks         = '0;
                end
            end
        end else begin
            if (!is_down && (now - last_edge_ms) > cfg.debounce_ms) begin
                last_edge_ms = now;
                is_down      = 1'b1;
                click_open   = 1'b1;
            end
            if (is_down && (now - last_edge_ms) > cfg.hold_ms) begin
                if (origin_armed) begin
                    origin_armed   = 1'b0;
                    hold_origin_ms = now;
                end
                last_edge_ms   = now;
                click_open     = 1'b0;
                clicks         = '0;
                res.event_code = EV_HOLD;
            end else if (origin_armed) begin
                origin_armed   = 1'b0;
                hold_origin_ms = now;
            end
        end
        res.hold_duration_ms = held_len_ms;
    endtask

    task automatic flag_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg            = {DEBOUNCE_RST, CLICK_GAP_RST, HOLD_RST, HOLD_MIN_RST};
            last_edge_ms   = '0;
            hold_origin_ms = '0;
            held_len_ms    = '0;
            click_open     = 1'b0;
            is_down        = 1'b0;
            origin_armed   = 1'b1;
            clicks         = '0;
            expected_events.delete();
            mismatch_cnt   = 0;
            in_flight      = 0;
            result_idx     = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_DEBOUNCE:  cfg.debounce_ms        = i_pwdata[CFG_BITS-1:0];
                    REG_CLICK_GAP: cfg.click_gap_ms       = i_pwdata[CFG_BITS-1:0];
                    REG_HOLD:      cfg.hold_ms            = i_pwdata[CFG_BITS-1:0];
                    REG_HOLD_MIN:  cfg.hold_report_min_ms = i_pwdata[CFG_BITS-1:0];
                    default: ;
                endcase
            end

            // retire the oldest expectation before queuing the poll taken at this edge
            if (i_res_valid && i_res_ready) begin
                if (expected_events.size() == 0) begin
                    flag_mismatch($sformatf(
                        "result %0d with nothing expected: code=%0d dur=%0d upd=%0b",
                        result_idx, i_event_code, i_hold_duration_ms,
                        i_hold_duration_updated));
                end else begin
                    oldest = expected_events.pop_front();
                    in_flight--;
                    if (oldest.event_code !== i_event_code
                        || oldest.hold_duration_ms !== i_hold_duration_ms
                        || oldest.hold_duration_updated !== i_hold_duration_updated)
                        flag_mismatch($sformatf(
                            "result %0d: exp code=%0d dur=%0d upd=%0b, got code=%0d dur=%0d upd=%0b",
                            result_idx, oldest.event_code, oldest.hold_duration_ms,
                            oldest.hold_duration_updated, i_event_code,
                            i_hold_duration_ms, i_hold_duration_updated));
                end
                result_idx++;
            end

            if (i_poll_valid && i_poll_ready) begin
                classify_poll(i_pin_level, i_now_ms, predicted);
                expected_events.push_back(predicted);
                in_flight++;
            end
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the button click/hold classifier: clock, reset, stimulus and verdict.
module tb_top;
    import bchc_pkg::*;

    localparam int DIRECTED_POLLS    = 25;
    localparam int POLLS_PER_SETTING = 132;
    localparam int N_SETTINGS        = 7;
    localparam int MIX_A_END         = 320;   // sender 23 %, receiver 45 % idle up to here
    localparam int MIX_B_END         = 640;   // then swapped, then no idling at all
    localparam int STALL_AT          = 200;
    localparam int STALL_CYCLES      = 300;
    localparam int QUIET_LIMIT       = 2000;
    localparam int DRAIN_CYCLES      = 10;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [APB_ABITS-1:0] paddr   = '0;
    logic [APB_DBITS-1:0] pwdata  = '0;
    logic [APB_DBITS-1:0] prdata;
    logic                 pready;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic                 i_pin_level = 1'b0;
    logic [31:0]          i_now_ms    = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic [2:0]           o_event_code;
    logic [31:0]          o_hold_duration_ms;
    logic                 o_hold_duration_updated;

    int                   mismatches;
    int                   outstanding;

    int                   polls_sent = 0;
    logic [31:0]          clock_ms   = '0;   // millisecond stamp, advanced by each poll and fed to the block
    t_cfg                 active_cfg;
    int                   quiet_cycles = 0;
    int                   stall_left   = 0;
    bit                   stall_done   = 1'b0;

    always #4 i_clk = ~i_clk;

    button_click_hold_classifier u_dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .psel                    (psel),
        .penable                 (penable),
        .pwrite                  (pwrite),
        .paddr                   (paddr),
        .pwdata                  (pwdata),
        .prdata                  (prdata),
        .pready                  (pready),
        .i_valid                 (i_valid),
        .o_ready                 (o_ready),
        .i_pin_level             (i_pin_level),
        .i_now_ms                (i_now_ms),
        .o_valid                 (o_valid),
        .i_ready                 (i_ready),
        .o_event_code            (o_event_code),
        .o_hold_duration_ms      (o_hold_duration_ms),
        .o_hold_duration_updated (o_hold_duration_updated)
    );

    bchc_checker u_check (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_psel                  (psel),
        .i_penable               (penable),
        .i_pwrite                (pwrite),
        .i_pready                (pready),
        .i_paddr                 (paddr),
        .i_pwdata                (pwdata),
        .i_poll_valid            (i_valid),
        .i_poll_ready            (o_ready),
        .i_pin_level             (i_pin_level),
        .i_now_ms                (i_now_ms),
        .i_res_valid             (o_valid),
        .i_res_ready             (i_ready),
        .i_event_code            (o_event_code),
        .i_hold_duration_ms      (o_hold_duration_ms),
        .i_hold_duration_updated (o_hold_duration_updated),
        .o_mismatches            (mismatches),
        .o_outstanding           (outstanding)
    );

    // Idle percentage for either side, following the three mixes of the run.
    function automatic int idle_pct(input bit sink);
        if (polls_sent < MIX_A_END)
            return sink ? 45 : 23;
        if (polls_sent < MIX_B_END)
            return sink ? 23 : 45;
        return 0;
    endfunction

    // Result sink: random stalls, plus one long hold-off once enough polls went in.
    // The long hold-off lets the block fill up and drop o_ready while polls keep coming.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_ready <= 1'b0;
        end else if (!stall_done && polls_sent >= STALL_AT) begin
            stall_done = 1'b1;
            stall_left = STALL_CYCLES - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
        end
    end

    // Watchdog: end the run when no beat moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one poll beat and hold it until the block takes it.
    // Idle gaps drop valid first; a held valid is never lowered and raised in one step.
    task automatic send_poll(input logic level, input logic [31:0] stamp);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct(1'b0)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_pin_level <= level;
        i_now_ms    <= stamp;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        polls_sent++;
    endtask

    // Advance the millisecond stamp (wrapping at 32 bits) and send a poll at it.
    task automatic step_poll(input logic level, input logic [31:0] delta_ms);
        clock_ms = clock_ms + delta_ms;
        send_poll(level, clock_ms);
    endtask

    // Land near a threshold: a couple of ms either side, never negative.
    function automatic int jitter(input int base);
        int j;
        j = base + int'($urandom_range(0, 4)) - 2;
        return (j < 0) ? 0 : j;
    endfunction

    // Drop valid and wait until every expected result beat is back, then let the block settle.
    task automatic wait_quiet();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the edge that ends it.
    // Fill the upper half of pwdata with noise, the block has to drop it.
    task automatic apb_write(input logic [1:0] idx, input logic [CFG_BITS-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom()), value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Register settings of the run: reset values, all zero, all ones, tiny, mixed, random.
    function automatic t_cfg preset(input int k);
        case (k)
            0: return {DEBOUNCE_RST, CLICK_GAP_RST, HOLD_RST, HOLD_MIN_RST};
            1: return '0;
            2: return '1;
            3: return {16'd4, 16'd16, 16'd60, 16'd25};
            4: return {16'd0, 16'hFFFF, 16'd1, 16'd0};
            5: return {16'd120, 16'd30, 16'd400, 16'd2000};
            default: return {16'($urandom_range(0, 300)), 16'($urandom_range(0, 800)),
                             16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000))};
        endcase
    endfunction

    // Directed polls under the reset settings (debounce 50, gap 200, hold 1000, min 500):
    // single click, four quick clicks saturating at triple, a hold with one repeat and
    // its recorded length, then a press that is debounced across the 32-bit wrap.
    function automatic logic [32:0] directed_beat(input int idx);
        case (idx)
            0:  return {1'b0, 32'd0};
            1:  return {1'b1, 32'd10};      // too early, but arms the hold start
            2:  return {1'b1, 32'd51};      // press accepted
            3:  return {1'b0, 32'd71};      // click counted without debounce
            4:  return {1'b0, 32'd131};     // debounced release, short press
            5:  return {1'b0, 32'd381};     // gap passed: single
            6:  return {1'b1, 32'd441};
            7:  return {1'b0, 32'd451};
            8:  return {1'b0, 32'd511};
            9:  return {1'b1, 32'd571};
            10: return {1'b0, 32'd581};
            11: return {1'b0, 32'd641};
            12: return {1'b1, 32'd701};
            13: return {1'b0, 32'd711};
            14: return {1'b0, 32'd771};
            15: return {1'b1, 32'd831};
            16: return {1'b0, 32'd841};     // fourth click, count stays at three
            17: return {1'b0, 32'd901};
            18: return {1'b0, 32'd1151};    // triple
            19: return {1'b1, 32'd1211};
            20: return {1'b1, 32'd2212};    // hold
            21: return {1'b1, 32'd3213};    // hold repeat
            22: return {1'b0, 32'd3273};    // release records the hold length
            23: return {1'b0, 32'hFFFF_FFF0};
            default: return {1'b1, 32'h0000_0030};
        endcase
    endfunction

    // One random gesture scaled to the live settings: mostly clean clicks, holds and
    // gap flushes, the rest contact bounce, loose polls and big jumps of the stamp.
    task automatic play_gesture();
        int pick;
        int n;
        int db;
        int gap;
        int hold;
        db   = active_cfg.debounce_ms;
        gap  = active_cfg.click_gap_ms;
        hold = active_cfg.hold_ms;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            step_poll(1'b1, jitter(db) + 1);
            n = $urandom_range(0, 2);
            repeat (n) step_poll(1'b1, $urandom_range(0, hold / 4));
            step_poll(1'b0, $urandom_range(0, gap / 2));
            step_poll(1'b0, jitter(db) + 1);
        end else if (pick < 55) begin
            step_poll(1'b0, jitter(gap));
            step_poll(1'b0, $urandom_range(0, gap + 2));
        end else if (pick < 70) begin
            step_poll(1'b1, jitter(db) + 1);
            n = $urandom_range(1, 4);
            repeat (n) step_poll(1'b1, jitter(hold) + 1);
            step_poll(1'b0, jitter(db) + 1);
            step_poll(1'b0, jitter(db));
        end else if (pick < 85) begin
            n = $urandom_range(2, 6);
            repeat (n) step_poll(1'($urandom_range(0, 1)), $urandom_range(0, db + 1));
        end else if (pick < 95) begin
            step_poll(1'($urandom_range(0, 1)), $urandom_range(0, 3 * hold + 3));
        end else begin
            step_poll(1'($urandom_range(0, 1)), $urandom());
        end
    endtask

    initial begin
        int          k;
        int          phase_start;
        logic [32:0] beat;
        active_cfg = preset(0);

        // hold reset, then release it on a falling edge
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < DIRECTED_POLLS; k++) begin
            beat     = directed_beat(k);
            clock_ms = beat[31:0];
            send_poll(beat[32], beat[31:0]);
        end

        // write every register for each setting, only while the block is idle
        for (k = 0; k < N_SETTINGS; k++) begin
            wait_quiet();
            active_cfg = preset(k);
            apb_write(REG_DEBOUNCE,  active_cfg.debounce_ms);
            apb_write(REG_CLICK_GAP, active_cfg.click_gap_ms);
            apb_write(REG_HOLD,      active_cfg.hold_ms);
            apb_write(REG_HOLD_MIN,  active_cfg.hold_report_min_ms);
            phase_start = polls_sent;
            while (polls_sent - phase_start < POLLS_PER_SETTING)
                play_gesture();
        end

        wait_quiet();
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bchc_pkg.sv
rtl/bchc_cfg.sv
rtl/bchc_core.sv
rtl/bchc_out.sv
rtl/button_click_hold_classifier.sv
tb/sv/bchc_checker.sv
tb/sv/tb_top.sv
